// ----- rtl/core/cadj_pkg.sv -----
package cadj_pkg;

  localparam int unsigned FRACTION_BITS = 20;
  localparam int unsigned MANT_BITS     = 30;
  localparam int unsigned MANT_W        = MANT_BITS + 1;
  localparam int unsigned CHAN_W        = 16;
  localparam int unsigned KNEE_W        = 15;
  localparam int unsigned GAMMA_W       = 9;
  localparam int unsigned PCT_W         = 8;
  localparam int unsigned MAG_W         = FRACTION_BITS + 4;
  localparam int unsigned PROD_W        = MAG_W + GAMMA_W;
  localparam int unsigned PAR_W         = PROD_W - 6;
  localparam int unsigned SH_W          = PAR_W - FRACTION_BITS;
  localparam int unsigned Y_W           = MANT_W + KNEE_W;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [KNEE_W-1:0]  KNEE       = 15'd32767;
  localparam logic [CHAN_W-1:0]  CHAN_MAX   = 16'hffff;
  localparam logic [GAMMA_W-1:0] GAMMA_ONE  = 9'd100;
  localparam logic [GAMMA_W-1:0] GAMMA_ZERO = 9'd0;
  localparam logic [PCT_W-1:0]   PCT_ONE    = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LUM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT   = 2'd2;

  typedef struct packed {
    logic [GAMMA_W-1:0] gamma;
    logic [PCT_W-1:0]   lum;
    logic [PCT_W-1:0]   sat;
  } cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] b;
    a   = a_in;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (a >= res + b) begin
        a   = a - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q30, built by repeated square roots of one half.
  function automatic logic [63:0] root_at(input int unsigned k);
    logic [63:0] t;
    t = 64'd1 << (MANT_BITS - 1);
    for (int unsigned j = 1; j <= FRACTION_BITS; j++) begin
      if (j <= k) t = isqrt64(t << MANT_BITS);
    end
    return t;
  endfunction

  function automatic logic [63:0] log2_fixed(input logic [15:0] v);
    logic [63:0] x;
    logic [63:0] fr;
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < 15; i++) begin
      if ((v >> (i + 1)) != 0) n = i + 1;
    end
    x  = 64'(v) << (MANT_BITS - n);
    fr = '0;
    for (int unsigned i = 0; i < FRACTION_BITS; i++) begin
      x  = (x * x) >> MANT_BITS;
      fr = fr << 1;
      if (x >= (64'd1 << (MANT_BITS + 1))) begin
        x  = x >> 1;
        fr = fr | 64'd1;
      end
    end
    return (64'(n) << FRACTION_BITS) | fr;
  endfunction

  localparam logic [MAG_W-1:0] LOG_KNEE = MAG_W'(log2_fixed({1'b0, KNEE}));

  function automatic logic [CHAN_W-1:0] widen(input logic [4:0] c);
    return {c, c[4:2], c, c[4:2]};
  endfunction

endpackage

// ----- rtl/core/rgb555_color_adjust.sv -----
// Converts one RGB555 color per clock into RGB888 after saturation, gamma and
// luminance adjustment. A new color is taken every clock while the input is not
// stalled. Each channel lane's gamma unit spends one squaring stage per log2
// fraction bit and one multiply stage per exp2 fraction bit.
// Two output slots decouple the stream: the input stalls only when both are full.
// Configuration writes are taken at any time but must happen while no color is in
// flight. Gamma results may be one LSB below an exact evaluation.
module rgb555_color_adjust (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [14:0] color_in, [15] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [cadj_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam logic [19:0] Recip3 = 20'((64'd1 << 20) / 64'd3);

  cadj_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gamma <= cadj_pkg::GAMMA_ONE;
      cfg_q.lum   <= cadj_pkg::PCT_ONE;
      cfg_q.sat   <= cadj_pkg::PCT_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cadj_pkg::CFG_GAMMA: cfg_q.gamma <= cfg_data_i;
        cadj_pkg::CFG_LUM:   cfg_q.lum   <= cfg_data_i[7:0];
        cadj_pkg::CFG_SAT:   cfg_q.sat   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic en;

  // Front end: widen channels, then the gray mean over two stages.
  logic        t1_vld_q, t2_vld_q, t3_vld_q;
  logic [15:0] ch1_q [3], ch2_q [3], ch3_q [3];
  logic [17:0] sum1_q, sum2_q;
  logic [15:0] q0_q, gray_q;
  logic [37:0] m3;
  logic [17:0] rem3;

  assign s_axis_tready = en;
  assign m3   = 38'(sum1_q) * 38'(Recip3);
  assign rem3 = sum2_q - 18'(18'(q0_q) * 18'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
      t3_vld_q <= 1'b0;
    end else if (en) begin
      t1_vld_q <= s_axis_tvalid;
      t2_vld_q <= t1_vld_q;
      t3_vld_q <= t2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ch1_q[0] <= cadj_pkg::widen(s_axis_tdata[14:10]);
      ch1_q[1] <= cadj_pkg::widen(s_axis_tdata[9:5]);
      ch1_q[2] <= cadj_pkg::widen(s_axis_tdata[4:0]);
      sum1_q   <= 18'(cadj_pkg::widen(s_axis_tdata[14:10]))
                + 18'(cadj_pkg::widen(s_axis_tdata[9:5]))
                + 18'(cadj_pkg::widen(s_axis_tdata[4:0]));
      ch2_q    <= ch1_q;
      sum2_q   <= sum1_q;
      q0_q     <= 16'(m3 >> 20);
      ch3_q    <= ch2_q;
      gray_q   <= q0_q + 16'(rem3 >= 18'd3);
    end
  end

  logic       lane_vld  [3];
  logic [7:0] lane_byte [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    cadj_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .cfg_i   (cfg_q),
      .valid_i (t3_vld_q),
      .ch_i    (ch3_q[i]),
      .gray_i  (gray_q),
      .valid_o (lane_vld[i]),
      .byte_o  (lane_byte[i])
    );
  end

  cadj_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lane_vld[0] & lane_vld[1] & lane_vld[2]),
    .data_i  ({lane_byte[2], lane_byte[1], lane_byte[0]}),
    .en_o    (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({lane_vld[0], lane_vld[1], lane_vld[2]}) == 0 ||
    $countones({lane_vld[0], lane_vld[1], lane_vld[2]}) == 3)
    else $error("channel lanes out of step");
`endif

endmodule

// ----- rtl/core/cadj_div100.sv -----
module cadj_div100 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [23:0] x_i,
  output logic        valid_o,
  output logic [17:0] q_o
);

  localparam int unsigned DivSh = 22;
  localparam logic [17:0] Recip = 18'((64'd1 << DivSh) / 64'd100);

  logic        v1_q, v2_q;
  logic [23:0] x1_q;
  logic [17:0] q0_q, q_q;
  logic [41:0] m;
  logic [23:0] rem;

  // The reciprocal is rounded down, so the estimate is exact or one low.
  assign m   = 42'(x_i) * 42'(Recip);
  assign rem = x1_q - 24'(24'(q0_q) * 24'd100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= x_i;
      q0_q <= 18'(m >> DivSh);
      q_q  <= q0_q + 18'(rem >= 24'd100);
    end
  end

  assign valid_o = v2_q;
  assign q_o     = q_q;

endmodule

// ----- rtl/core/cadj_log2.sv -----
module cadj_log2 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [15:0]               v_i,
  output logic                      valid_o,
  output logic [15:0]               v_o,
  output logic [cadj_pkg::MAG_W-1:0] mag_o
);

  localparam int unsigned NS = cadj_pkg::FRACTION_BITS;
  localparam int unsigned MW = cadj_pkg::MANT_W;
  localparam int unsigned MB = cadj_pkg::MANT_BITS;

  logic          vld_q [0:NS];
  logic [15:0]   v_q   [0:NS];
  logic [3:0]    n_q   [0:NS];
  logic [MW-1:0] x_q   [0:NS];
  logic [NS-1:0] fr_q  [0:NS];

  logic          out_vld_q;
  logic [15:0]   out_v_q;
  logic [cadj_pkg::MAG_W-1:0] mag_q;

  logic [3:0]    n_d;
  logic [4:0]    sh_d;
  logic [MW-1:0] x_d;

  // Normalize to a mantissa in [1,2). A zero input gets mantissa one; its result is unused.
  always_comb begin
    n_d = '0;
    for (int i = 1; i < 15; i++) begin
      if (v_i[i]) n_d = 4'(i);
    end
    sh_d = 5'(MB) - {1'b0, n_d};
    x_d  = MW'(v_i[14:0]) << sh_d;
    if (v_i[14:0] == '0) x_d = MW'(1) << MB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0]  <= v_i;
      n_q[0]  <= n_d;
      x_q[0]  <= x_d;
      fr_q[0] <= '0;
    end
  end

  // One fraction bit per stage: square, and renormalize if it reached two.
  for (genvar i = 1; i <= NS; i++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     t;

    assign sq = x_q[i-1] * x_q[i-1];
    assign t  = sq[MB +: MW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[i]  <= v_q[i-1];
        n_q[i]  <= n_q[i-1];
        x_q[i]  <= t[MW] ? t[MW:1] : t[MW-1:0];
        fr_q[i] <= {fr_q[i-1][NS-2:0], t[MW]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_v_q <= v_q[NS];
      mag_q   <= cadj_pkg::LOG_KNEE - {n_q[NS], fr_q[NS]};
    end
  end

  assign valid_o = out_vld_q;
  assign v_o     = out_v_q;
  assign mag_o   = mag_q;

endmodule

// ----- rtl/core/cadj_exp2.sv -----
module cadj_exp2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [15:0]                v_i,
  input  logic [cadj_pkg::PAR_W-1:0] p_i,
  output logic                       valid_o,
  output logic [15:0]                v_o,
  output logic [cadj_pkg::MANT_W-1:0] acc_o,
  output logic [cadj_pkg::SH_W-1:0]  sh_o
);

  localparam int unsigned NS = cadj_pkg::FRACTION_BITS;
  localparam int unsigned MW = cadj_pkg::MANT_W;
  localparam int unsigned MB = cadj_pkg::MANT_BITS;

  logic                      vld_q [0:NS];
  logic [15:0]               v_q   [0:NS];
  logic [MW-1:0]             acc_q [0:NS];
  logic [NS-1:0]             f_q   [0:NS];
  logic [cadj_pkg::SH_W-1:0] sh_q  [0:NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0]   <= v_i;
      acc_q[0] <= MW'(1) << MB;
      f_q[0]   <= p_i[NS-1:0];
      sh_q[0]  <= p_i[cadj_pkg::PAR_W-1:NS];
    end
  end

  // Stage k multiplies by 2^(-2^-k) when the matching fraction bit is set.
  for (genvar k = 1; k <= NS; k++) begin : g_mul
    localparam logic [MW-1:0] Root = MW'(cadj_pkg::root_at(k));
    logic [2*MW-1:0] m;

    assign m = acc_q[k-1] * Root;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]   <= v_q[k-1];
        f_q[k]   <= f_q[k-1];
        sh_q[k]  <= sh_q[k-1];
        acc_q[k] <= f_q[k-1][NS-k] ? m[MB +: MW] : acc_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign v_o     = v_q[NS];
  assign acc_o   = acc_q[NS];
  assign sh_o    = sh_q[NS];

endmodule

// ----- rtl/core/cadj_lane.sv -----
module cadj_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cadj_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  input  logic [15:0]          ch_i,
  input  logic [15:0]          gray_i,
  output logic                 valid_o,
  output logic [7:0]           byte_o
);

  localparam int unsigned PW = cadj_pkg::PROD_W;
  localparam int unsigned QW = cadj_pkg::PAR_W;
  localparam int unsigned YW = cadj_pkg::Y_W;
  localparam logic [QW-1:0] RecipP = QW'((64'd1 << PW) / 64'd100);

  // Saturation mix.
  logic        a_vld_q;
  logic [23:0] a_x_q;
  logic [6:0]  inv;

  assign inv = (cfg_i.sat < cadj_pkg::PCT_ONE) ? 7'(cadj_pkg::PCT_ONE - cfg_i.sat) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) a_x_q <= 24'(25'(ch_i) * 25'(cfg_i.sat) + 25'(gray_i) * 25'(inv));
  end

  logic        s_vld;
  logic [17:0] s_q;
  logic [15:0] v_sat;

  cadj_div100 u_div_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (a_vld_q),
    .x_i     (a_x_q),
    .valid_o (s_vld),
    .q_o     (s_q)
  );

  assign v_sat = (s_q > 18'(cadj_pkg::CHAN_MAX)) ? cadj_pkg::CHAN_MAX : s_q[15:0];

  // Gamma: log2 of the ratio to the knee, scale by gamma, then exp2.
  logic                       l_vld;
  logic [15:0]                l_v;
  logic [cadj_pkg::MAG_W-1:0] l_mag;

  cadj_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s_vld),
    .v_i     (v_sat),
    .valid_o (l_vld),
    .v_o     (l_v),
    .mag_o   (l_mag)
  );

  logic          b_vld_q, c_vld_q, d_vld_q;
  logic [15:0]   b_v_q, c_v_q, d_v_q;
  logic [PW-1:0] b_prod_q, c_prod_q;
  logic [QW-1:0] c_q0_q, d_p_q;
  logic [PW+QW-1:0] c_m;
  logic [PW-1:0] d_rem;

  assign c_m   = (PW+QW)'(b_prod_q) * (PW+QW)'(RecipP);
  assign d_rem = c_prod_q - PW'(PW'(c_q0_q) * PW'(100));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= l_vld;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_v_q    <= l_v;
      b_prod_q <= PW'(l_mag) * PW'(cfg_i.gamma) + PW'(50);
      c_v_q    <= b_v_q;
      c_prod_q <= b_prod_q;
      c_q0_q   <= QW'(c_m >> PW);
      d_v_q    <= c_v_q;
      d_p_q    <= c_q0_q + QW'(d_rem >= PW'(100));
    end
  end

  logic                        e_vld;
  logic [15:0]                 e_v;
  logic [cadj_pkg::MANT_W-1:0] e_acc;
  logic [cadj_pkg::SH_W-1:0]   e_sh;

  cadj_exp2 u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (d_vld_q),
    .v_i     (d_v_q),
    .p_i     (d_p_q),
    .valid_o (e_vld),
    .v_o     (e_v),
    .acc_o   (e_acc),
    .sh_o    (e_sh)
  );

  logic                      y_vld_q, f_vld_q, g_vld_q;
  logic [15:0]               y_v_q;
  logic [YW-1:0]             y_q;
  logic [cadj_pkg::SH_W-1:0] y_sh_q;
  logic [15:0]               ym, gv_d, gv_q;
  logic [23:0]               z_q;

  assign ym = y_q[cadj_pkg::MANT_BITS +: 16];

  // Gamma one and values above the knee pass, then gamma zero pins to the knee, then zero stays zero.
  always_comb begin
    if (cfg_i.gamma == cadj_pkg::GAMMA_ONE || y_v_q > 16'(cadj_pkg::KNEE)) begin
      gv_d = y_v_q;
    end else if (cfg_i.gamma == cadj_pkg::GAMMA_ZERO) begin
      gv_d = 16'(cadj_pkg::KNEE);
    end else if (y_v_q == '0) begin
      gv_d = '0;
    end else begin
      gv_d = ym >> y_sh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else if (en_i) begin
      y_vld_q <= e_vld;
      f_vld_q <= y_vld_q;
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_v_q  <= e_v;
      y_sh_q <= e_sh;
      y_q    <= YW'(e_acc) * YW'(cadj_pkg::KNEE);
      gv_q   <= gv_d;
      z_q    <= 24'(gv_q) * 24'(cfg_i.lum);
    end
  end

  // Luminance scale and top byte.
  logic        h_vld;
  logic [17:0] h_q;
  logic        o_vld_q;
  logic [7:0]  o_byte_q;

  cadj_div100 u_div_lum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (g_vld_q),
    .x_i     (z_q),
    .valid_o (h_vld),
    .q_o     (h_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      o_vld_q <= h_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) o_byte_q <= (h_q > 18'(cadj_pkg::CHAN_MAX)) ? 8'hff : h_q[15:8];
  end

  assign valid_o = o_vld_q;
  assign byte_o  = o_byte_q;

endmodule

// ----- rtl/core/cadj_skid.sv -----
module cadj_skid (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [23:0] data_i,
  output logic        en_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [23:0] data_o
);

  logic        out_vld_q, skd_vld_q;
  logic [23:0] out_q, skd_q;
  logic        push;

  // The pipeline advances unless the spare slot is taken.
  assign en_o = ~skd_vld_q;
  assign push = valid_i & en_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else if (!out_vld_q || ready_i) begin
      out_vld_q <= skd_vld_q | push;
      skd_vld_q <= 1'b0;
    end else if (push) begin
      skd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || ready_i) begin
      out_q <= skd_vld_q ? skd_q : data_i;
    end else if (push) begin
      skd_q <= data_i;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skd_vld_q |-> out_vld_q)
    else $error("spare slot holds a transfer while the output slot is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skd_vld_q) |-> $past(out_vld_q && !ready_i && valid_i))
    else $error("spare slot filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skd_vld_q && ready_i |=> out_vld_q && !skd_vld_q)
    else $error("spare slot did not move to the output");
`endif

endmodule
